// ----- src/vah_pkg.sv -----
// Shared types, constants and helpers of the activity heap block.
`default_nettype none
package vah_pkg;

	localparam int NUM_VARS     = 256;
	localparam int CLAUSE_WIDTH = 3;
	localparam int VAR_W        = $clog2(NUM_VARS + 1);
	localparam int IDX_W        = $clog2(NUM_VARS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int K_W          = 2;
	localparam int SCORE_W      = 32;
	localparam int GF_W         = 17;
	localparam int BUMP_W       = 31;
	localparam int SH_W         = 5;
	localparam int PROD_W       = BUMP_W + GF_W;
	localparam int APB_AW       = 4;
	localparam int APB_DW       = 32;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SCORE_W-1:0] ONE_Q16   = 32'sh0001_0000;
	localparam logic [BUMP_W-1:0] BUMP_MAX          = 31'h7FFF_FFFF;

	localparam logic [GF_W-1:0]   RST_GROWTH = 17'd68985;
	localparam logic [BUMP_W-1:0] RST_BUMP   = 31'd65536;
	localparam logic [BUMP_W-1:0] RST_THRESH = 31'd1073741824;
	localparam logic [SH_W-1:0]   RST_SHIFT  = 5'd14;

	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_COUNT = 3'd1;
	localparam logic [2:0] REQ_BUMP  = 3'd2;
	localparam logic [2:0] REQ_DEACT = 3'd3;
	localparam logic [2:0] REQ_REACT = 3'd4;

	localparam logic [1:0] REG_GROWTH = 2'd0;
	localparam logic [1:0] REG_BUMP   = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_SHIFT  = 2'd3;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [VAR_W-1:0] var_a;
		logic [VAR_W-1:0] var_b;
		logic [VAR_W-1:0] var_c;
	} req_t;

	typedef struct packed {
		logic [VAR_W-1:0]          top_var;
		logic signed [SCORE_W-1:0] top_score;
		logic                      did_scale;
	} rsp_t;

	typedef struct packed {
		logic [GF_W-1:0]   growth_factor;
		logic [BUMP_W-1:0] init_bump;
		logic [BUMP_W-1:0] scale_threshold;
		logic [SH_W-1:0]   scale_shift;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_FILL_RST, OP_FILL_CLR, OP_BMUL, OP_BSAT, OP_NEXT, OP_MOD,
		OP_UP_P, OP_UP_PV, OP_UP_CMP, OP_PLACE, OP_DN_L, OP_DN_LV, OP_DN_RV,
		OP_DN_CMP, OP_SCALE, OP_TOP0, OP_TOP1, OP_TOP2
	} op_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [2:0] in_type;
		logic       fill_last;
		logic       scale_last;
		logic       var_ok;
		logic       vars_done;
		logic       trig;
		logic       idx_zero;
		logic       up_go;
		logic       leaf;
		logic       dn_go;
		logic       out_free;
	} status_t;

	function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SCORE_W:0] x);
		logic signed [SCORE_W:0] hi;
		logic signed [SCORE_W:0] lo;
		begin
			hi = (SCORE_W+1)'(SCORE_MAX);
			lo = -hi;
			if (x > hi) begin
				sat_score = SCORE_MAX;
			end else if (x < lo) begin
				sat_score = -SCORE_MAX;
			end else begin
				sat_score = x[SCORE_W-1:0];
			end
		end
	endfunction

endpackage
`default_nettype wire

// ----- src/vah_regs.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none
module vah_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vah_pkg::APB_AW-1:0] paddr,
	input  logic [vah_pkg::APB_DW-1:0] pwdata,
	output logic [vah_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output vah_pkg::cfg_t              cfg
);
	import vah_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.growth_factor   <= RST_GROWTH;
			cfg_q.init_bump       <= RST_BUMP;
			cfg_q.scale_threshold <= RST_THRESH;
			cfg_q.scale_shift     <= RST_SHIFT;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_GROWTH: cfg_q.growth_factor   <= pwdata[GF_W-1:0];
				REG_BUMP:   cfg_q.init_bump       <= pwdata[BUMP_W-1:0];
				REG_THRESH: cfg_q.scale_threshold <= pwdata[BUMP_W-1:0];
				REG_SHIFT:  cfg_q.scale_shift     <= pwdata[SH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_GROWTH: prdata = APB_DW'(cfg_q.growth_factor);
			REG_BUMP:   prdata = APB_DW'(cfg_q.init_bump);
			REG_THRESH: prdata = APB_DW'(cfg_q.scale_threshold);
			REG_SHIFT:  prdata = APB_DW'(cfg_q.scale_shift);
			default:    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/vah_datapath.sv -----
// Score, heap and position memories with the sift, bump and scale datapath.
`default_nettype none
module vah_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  vah_pkg::op_t        op,
	input  logic                req_valid,
	input  vah_pkg::req_t       req_data,
	input  vah_pkg::cfg_t       cfg,
	input  logic                rsp_stall,
	output vah_pkg::status_t    st,
	output logic                rsp_valid,
	output vah_pkg::rsp_t       rsp_data
);
	import vah_pkg::*;

	logic signed [SCORE_W-1:0] sc_mem [NUM_VARS];
	logic [IDX_W-1:0]          hp_mem [NUM_VARS];
	logic [IDX_W-1:0]          sv_mem [NUM_VARS];

	logic [IDX_W-1:0]          sc_raddr, sc_waddr, hp_raddr, hp_waddr, sv_raddr, sv_waddr;
	logic                      sc_we, hp_we, sv_we;
	logic signed [SCORE_W-1:0] sc_wdata, sc_rdata;
	logic [IDX_W-1:0]          hp_wdata, hp_rdata, sv_wdata, sv_rdata;

	req_t                      req_q;
	logic [K_W-1:0]            k_q;
	logic                      trig_q, did_q, rsp_valid_q;
	logic [BUMP_W-1:0]         bump_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [PROD_W-1:0]         prod_q;
	logic [IDX_W-1:0]          v_q, idx_q, pv_q, lv_q, rv_q, topv_q;
	logic signed [SCORE_W-1:0] s_q, ls_q;
	rsp_t                      rsp_q;

	logic [VAR_W-1:0]          cur_var;
	logic [IDX_W-1:0]          cur_idx, parent;
	logic [K_W-1:0]            lim;
	logic                      vars_done, var_ok, out_free, has_r, pick_r;
	logic [CNT_W-1:0]          l9, r9;
	logic signed [SCORE_W-1:0] s_old, s_new, rs, cs, scaled;
	logic signed [SCORE_W:0]   s_ext, b_ext;
	logic [SCORE_W-1:0]        mag;
	logic [SCORE_W-1:0]        nb;
	logic                      up_go, dn_go, bump_trig;
	logic [IDX_W-1:0]          pick_idx, pick_var;

	always_ff @(posedge clk) begin
		if (sc_we) begin
			sc_mem[sc_waddr] <= sc_wdata;
		end
		sc_rdata <= sc_mem[sc_raddr];
	end

	always_ff @(posedge clk) begin
		if (hp_we) begin
			hp_mem[hp_waddr] <= hp_wdata;
		end
		hp_rdata <= hp_mem[hp_raddr];
	end

	always_ff @(posedge clk) begin
		if (sv_we) begin
			sv_mem[sv_waddr] <= sv_wdata;
		end
		sv_rdata <= sv_mem[sv_raddr];
	end

	always_comb begin
		case (k_q)
			2'd0:    cur_var = req_q.var_a;
			2'd1:    cur_var = req_q.var_b;
			default: cur_var = req_q.var_c;
		endcase
		lim       = (req_q.req_type == REQ_BUMP) ? K_W'(CLAUSE_WIDTH) : K_W'(1);
		vars_done = k_q >= lim;
		var_ok    = !vars_done && (cur_var != '0) && (cur_var <= VAR_W'(NUM_VARS));
		cur_idx   = IDX_W'(cur_var - VAR_W'(1));
		parent    = (idx_q - IDX_W'(1)) >> 1;
		l9        = {idx_q, 1'b1};
		r9        = l9 + CNT_W'(1);
		has_r     = r9 < CNT_W'(NUM_VARS);
		out_free  = !rsp_valid_q || !rsp_stall;

		s_old = sc_rdata;
		s_ext = {s_old[SCORE_W-1], s_old};
		b_ext = {2'b00, bump_q};
		case (req_q.req_type)
			REQ_COUNT: s_new = sat_score(s_ext + {ONE_Q16[SCORE_W-1], ONE_Q16});
			REQ_BUMP:  s_new = (s_old >= 0) ? sat_score(s_ext + b_ext)
			                                : sat_score(s_ext - b_ext);
			REQ_DEACT: s_new = (s_old < 0) ? s_old : sat_score(-s_ext);
			default:   s_new = (s_old < 0) ? sat_score(-s_ext) : s_old;
		endcase
		bump_trig = s_new > $signed({1'b0, cfg.scale_threshold});

		up_go = s_q > sc_rdata;

		rs = sc_rdata;
		if (has_r) begin
			if (ls_q > 0 && rs > 0) begin
				pick_r = !(ls_q > rs);
			end else begin
				pick_r = !(ls_q > 0);
			end
		end else begin
			pick_r = 1'b0;
		end
		cs       = pick_r ? rs : ls_q;
		dn_go    = cs > 0;
		pick_idx = pick_r ? r9[IDX_W-1:0] : l9[IDX_W-1:0];
		pick_var = pick_r ? rv_q : lv_q;

		mag    = (sc_rdata < 0) ? SCORE_W'(-sc_rdata) : SCORE_W'(sc_rdata);
		mag    = mag >> cfg.scale_shift;
		scaled = (sc_rdata < 0) ? -$signed(mag) : $signed(mag);

		nb = prod_q[PROD_W-1:16];
	end

	always_comb begin
		sc_raddr = '0;
		hp_raddr = '0;
		sv_raddr = '0;
		sc_we    = 1'b0;
		hp_we    = 1'b0;
		sv_we    = 1'b0;
		sc_waddr = '0;
		hp_waddr = '0;
		sv_waddr = '0;
		sc_wdata = '0;
		hp_wdata = '0;
		sv_wdata = '0;
		case (op)
			OP_FILL_RST, OP_FILL_CLR: begin
				sc_we    = 1'b1;
				sc_waddr = cnt_q[IDX_W-1:0];
				sc_wdata = (op == OP_FILL_RST) ? $signed({1'b0, RST_BUMP}) : '0;
				hp_we    = 1'b1;
				hp_waddr = cnt_q[IDX_W-1:0];
				hp_wdata = cnt_q[IDX_W-1:0];
				sv_we    = 1'b1;
				sv_waddr = cnt_q[IDX_W-1:0];
				sv_wdata = cnt_q[IDX_W-1:0];
			end
			OP_NEXT: begin
				sc_raddr = cur_idx;
				sv_raddr = cur_idx;
			end
			OP_MOD: begin
				sc_we    = 1'b1;
				sc_waddr = v_q;
				sc_wdata = s_new;
			end
			OP_UP_P:  hp_raddr = parent;
			OP_UP_PV: sc_raddr = hp_rdata;
			OP_UP_CMP: begin
				hp_we    = up_go;
				hp_waddr = idx_q;
				hp_wdata = pv_q;
				sv_we    = up_go;
				sv_waddr = pv_q;
				sv_wdata = idx_q;
			end
			OP_PLACE: begin
				hp_we    = 1'b1;
				hp_waddr = idx_q;
				hp_wdata = v_q;
				sv_we    = 1'b1;
				sv_waddr = v_q;
				sv_wdata = idx_q;
			end
			OP_DN_L: hp_raddr = l9[IDX_W-1:0];
			OP_DN_LV: begin
				sc_raddr = hp_rdata;
				hp_raddr = r9[IDX_W-1:0];
			end
			OP_DN_RV: sc_raddr = hp_rdata;
			OP_DN_CMP: begin
				hp_we    = dn_go;
				hp_waddr = idx_q;
				hp_wdata = pick_var;
				sv_we    = dn_go;
				sv_waddr = pick_var;
				sv_wdata = idx_q;
			end
			OP_SCALE: begin
				sc_raddr = cnt_q[IDX_W-1:0];
				sc_we    = cnt_q != '0;
				sc_waddr = IDX_W'(cnt_q - CNT_W'(1));
				sc_wdata = scaled;
			end
			OP_TOP0: hp_raddr = '0;
			OP_TOP1: sc_raddr = hp_rdata;
			OP_TOP2: sc_raddr = topv_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			trig_q      <= 1'b0;
			did_q       <= 1'b0;
			bump_q      <= RST_BUMP;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (op)
				OP_IDLE: begin
					if (req_valid) begin
						k_q    <= '0;
						trig_q <= 1'b0;
						did_q  <= 1'b0;
						cnt_q  <= '0;
					end
				end
				OP_FILL_RST, OP_FILL_CLR: cnt_q <= cnt_q + CNT_W'(1);
				OP_BSAT: bump_q <= nb[SCORE_W-1] ? BUMP_MAX : nb[BUMP_W-1:0];
				OP_NEXT: begin
					if (!var_ok && !vars_done) begin
						k_q <= k_q + K_W'(1);
					end
				end
				OP_MOD: begin
					if (req_q.req_type == REQ_BUMP && bump_trig) begin
						trig_q <= 1'b1;
					end
				end
				OP_PLACE: k_q <= k_q + K_W'(1);
				OP_SCALE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					did_q <= 1'b1;
					if (cnt_q == '0) begin
						bump_q <= bump_q >> cfg.scale_shift;
					end
				end
				default: ;
			endcase
			if (op == OP_TOP2 && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_IDLE: begin
				if (req_valid) begin
					req_q <= req_data;
				end
			end
			OP_BMUL: prod_q <= PROD_W'(bump_q) * PROD_W'(cfg.growth_factor);
			OP_NEXT: v_q <= cur_idx;
			OP_MOD: begin
				s_q   <= s_new;
				idx_q <= sv_rdata;
			end
			OP_UP_PV: pv_q <= hp_rdata;
			OP_UP_CMP: begin
				if (up_go) begin
					idx_q <= parent;
				end
			end
			OP_DN_LV: lv_q <= hp_rdata;
			OP_DN_RV: begin
				ls_q <= sc_rdata;
				rv_q <= hp_rdata;
			end
			OP_DN_CMP: begin
				if (dn_go) begin
					idx_q <= pick_idx;
				end
			end
			OP_TOP1: topv_q <= hp_rdata;
			OP_TOP2: begin
				if (out_free) begin
					rsp_q.top_var   <= VAR_W'(topv_q) + VAR_W'(1);
					rsp_q.top_score <= sc_rdata;
					rsp_q.did_scale <= did_q;
				end
			end
			default: ;
		endcase
	end

	assign st.req_type   = req_q.req_type;
	assign st.in_type    = req_data.req_type;
	assign st.fill_last  = cnt_q[IDX_W-1:0] == IDX_W'(NUM_VARS - 1);
	assign st.scale_last = cnt_q == CNT_W'(NUM_VARS);
	assign st.var_ok     = var_ok;
	assign st.vars_done  = vars_done;
	assign st.trig       = trig_q;
	assign st.idx_zero   = idx_q == '0;
	assign st.up_go      = up_go;
	assign st.leaf       = l9 >= CNT_W'(NUM_VARS);
	assign st.dn_go      = dn_go;
	assign st.out_free   = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
`default_nettype wire

// ----- src/vah_ctrl.sv -----
// Sequencer that steps the datapath through each request.
`default_nettype none
module vah_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  vah_pkg::status_t st,
	output vah_pkg::op_t     op,
	output logic             req_stall
);
	import vah_pkg::*;

	typedef enum logic [18:0] {
		S_INIT   = 19'h00001,
		S_IDLE   = 19'h00002,
		S_BMUL   = 19'h00004,
		S_BSAT   = 19'h00008,
		S_NEXT   = 19'h00010,
		S_MOD    = 19'h00020,
		S_UP_P   = 19'h00040,
		S_UP_PV  = 19'h00080,
		S_UP_CMP = 19'h00100,
		S_PLACE  = 19'h00200,
		S_DN_L   = 19'h00400,
		S_DN_LV  = 19'h00800,
		S_DN_RV  = 19'h01000,
		S_DN_CMP = 19'h02000,
		S_CLR    = 19'h04000,
		S_SCALE  = 19'h08000,
		S_TOP0   = 19'h10000,
		S_TOP1   = 19'h20000,
		S_TOP2   = 19'h40000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		op      = OP_IDLE;
		unique case (state_q)
			S_INIT: begin
				op = OP_FILL_RST;
				if (st.fill_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				op = OP_IDLE;
				if (req_valid) begin
					state_d = S_TOP0;
					unique case (st.in_type) inside
						REQ_CLEAR:                       state_d = S_CLR;
						REQ_BUMP:                        state_d = S_BMUL;
						REQ_COUNT, REQ_DEACT, REQ_REACT: state_d = S_NEXT;
						default:                         state_d = S_TOP0;
					endcase
				end
			end
			S_CLR: begin
				op = OP_FILL_CLR;
				if (st.fill_last) state_d = S_TOP0;
			end
			S_BMUL: begin
				op      = OP_BMUL;
				state_d = S_BSAT;
			end
			S_BSAT: begin
				op      = OP_BSAT;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				op = OP_NEXT;
				if (st.vars_done) begin
					state_d = st.trig ? S_SCALE : S_TOP0;
				end else if (st.var_ok) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				op      = OP_MOD;
				state_d = (st.req_type == REQ_DEACT) ? S_DN_L : S_UP_P;
			end
			S_UP_P: begin
				op      = OP_UP_P;
				state_d = st.idx_zero ? S_PLACE : S_UP_PV;
			end
			S_UP_PV: begin
				op      = OP_UP_PV;
				state_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				op      = OP_UP_CMP;
				state_d = st.up_go ? S_UP_P : S_PLACE;
			end
			S_PLACE: begin
				op      = OP_PLACE;
				state_d = S_NEXT;
			end
			S_DN_L: begin
				op      = OP_DN_L;
				state_d = st.leaf ? S_PLACE : S_DN_LV;
			end
			S_DN_LV: begin
				op      = OP_DN_LV;
				state_d = S_DN_RV;
			end
			S_DN_RV: begin
				op      = OP_DN_RV;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				op      = OP_DN_CMP;
				state_d = st.dn_go ? S_DN_L : S_PLACE;
			end
			S_SCALE: begin
				op = OP_SCALE;
				if (st.scale_last) state_d = S_TOP0;
			end
			S_TOP0: begin
				op      = OP_TOP0;
				state_d = S_TOP1;
			end
			S_TOP1: begin
				op      = OP_TOP1;
				state_d = S_TOP2;
			end
			S_TOP2: begin
				op = OP_TOP2;
				if (st.out_free) state_d = S_IDLE;
			end
			default: begin
				op      = OP_IDLE;
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/vsids_activity_heap.sv -----
// Top level of the variable activity score heap.
// After reset the block fills its score, heap and position memories and takes
// no transaction until then. Each request is sequenced through memories with
// registered read data: a sift-up steps through UP_P, UP_PV and UP_CMP for each
// heap level climbed and a sift-down through DN_L, DN_LV, DN_RV and DN_CMP for each
// level descended (at most eight levels), plus setup and readout. A bump runs up
// to three sift-ups, and when it crosses the threshold adds a pass that rescales
// every score; a clear rewrites all three memories. The next transaction is
// accepted while a finished result still waits in the output register.
`default_nettype none
module vsids_activity_heap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  vah_pkg::req_t              req_data,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output vah_pkg::rsp_t              rsp_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vah_pkg::APB_AW-1:0] paddr,
	input  logic [vah_pkg::APB_DW-1:0] pwdata,
	output logic [vah_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import vah_pkg::*;

	cfg_t    cfg;
	op_t     op;
	status_t st;

	vah_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vah_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.st        (st),
		.op        (op),
		.req_stall (req_stall)
	);

	vah_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.req_valid (req_valid),
		.req_data  (req_data),
		.cfg       (cfg),
		.rsp_stall (rsp_stall),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

endmodule
`default_nettype wire

// ----- dv/vsids_activity_heap_test.sv -----
// Testbench for the activity heap: directed and random requests checked against a local model.
`timescale 1ns / 1ps
module vsids_activity_heap_test;
	import vah_pkg::*;

	localparam int STUCK_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	vsids_activity_heap dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	int act_score [NUM_VARS];
	int heap_slot [NUM_VARS];
	int slot_pos [NUM_VARS];
	longint bump_level;
	longint growth_q16;
	longint score_limit;
	int shift_amt;

	rsp_t expected_tops [$];
	int errors;
	int cycles;
	int stuck_cycles;
	int hold_until;
	bit calm;
	int var_span;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int clamp_score(longint s);
		if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -64'sd2147483647) return -32'sh7FFFFFFF;
		return int'(s);
	endfunction

	function automatic bit var_valid(int v);
		return v >= 1 && v <= NUM_VARS;
	endfunction

	function automatic void heap_restore();
		for (int i = 0; i < NUM_VARS; i++) begin
			heap_slot[i] = i + 1;
			slot_pos[i] = i;
		end
	endfunction

	function automatic void raise_var(int v);
		int idx;
		int s;
		int p;
		int pv;
		idx = slot_pos[v-1];
		s = act_score[v-1];
		while (idx > 0) begin
			p = (idx - 1) / 2;
			pv = heap_slot[p];
			if (!(s > act_score[pv-1])) break;
			heap_slot[idx] = pv;
			slot_pos[pv-1] = idx;
			idx = p;
		end
		heap_slot[idx] = v;
		slot_pos[v-1] = idx;
	endfunction

	function automatic void sink_var(int v);
		int idx;
		int l;
		int r;
		int pick;
		int ls;
		int rs;
		idx = slot_pos[v-1];
		forever begin
			l = idx * 2 + 1;
			r = idx * 2 + 2;
			if (l >= NUM_VARS) break;
			ls = act_score[heap_slot[l]-1];
			if (r < NUM_VARS) begin
				rs = act_score[heap_slot[r]-1];
				if (ls > 0 && rs > 0) pick = (ls > rs) ? l : r;
				else pick = (ls > 0) ? l : r;
			end else begin
				pick = l;
			end
			if (!(act_score[heap_slot[pick]-1] > 0)) break;
			heap_slot[idx] = heap_slot[pick];
			slot_pos[heap_slot[pick]-1] = idx;
			idx = pick;
		end
		heap_slot[idx] = v;
		slot_pos[v-1] = idx;
	endfunction

	function automatic int shrink_score(int s, int sh);
		longint w;
		longint m;
		w = s;
		m = (w < 0 ? -w : w) >> sh;
		return (w < 0) ? int'(-m) : int'(m);
	endfunction

	function automatic void model_reset();
		growth_q16 = RST_GROWTH;
		score_limit = RST_THRESH;
		shift_amt = RST_SHIFT;
		for (int i = 0; i < NUM_VARS; i++) act_score[i] = int'(RST_BUMP);
		heap_restore();
		bump_level = RST_BUMP;
	endfunction

	function automatic rsp_t predict_top(req_t rq);
		rsp_t res;
		int vars [3];
		int v;
		longint s;
		longint nb;
		bit trig;
		bit scaled;
		scaled = 1'b0;
		v = rq.var_a;
		case (rq.req_type)
			REQ_CLEAR: begin
				for (int i = 0; i < NUM_VARS; i++) act_score[i] = 0;
				heap_restore();
			end
			REQ_COUNT: begin
				if (var_valid(v)) begin
					act_score[v-1] = clamp_score(longint'(act_score[v-1]) + 65536);
					raise_var(v);
				end
			end
			REQ_BUMP: begin
				nb = (bump_level * growth_q16) >>> 16;
				bump_level = (nb > 64'sd2147483647) ? 64'sd2147483647 : nb;
				trig = 1'b0;
				vars[0] = rq.var_a;
				vars[1] = rq.var_b;
				vars[2] = rq.var_c;
				for (int k = 0; k < CLAUSE_WIDTH; k++) begin
					v = vars[k];
					if (var_valid(v)) begin
						s = act_score[v-1];
						s = (s >= 0) ? s + bump_level : s - bump_level;
						act_score[v-1] = clamp_score(s);
						if (longint'(act_score[v-1]) > score_limit) trig = 1'b1;
						raise_var(v);
					end
				end
				if (trig) begin
					scaled = 1'b1;
					bump_level = bump_level >> shift_amt;
					for (int i = 0; i < NUM_VARS; i++)
						act_score[i] = shrink_score(act_score[i], shift_amt);
				end
			end
			REQ_DEACT: begin
				if (var_valid(v)) begin
					s = act_score[v-1];
					act_score[v-1] = clamp_score(s < 0 ? s : -s);
					sink_var(v);
				end
			end
			REQ_REACT: begin
				if (var_valid(v)) begin
					s = act_score[v-1];
					act_score[v-1] = clamp_score(s < 0 ? -s : s);
					raise_var(v);
				end
			end
			default: ;
		endcase
		res.top_var = heap_slot[0];
		res.top_score = act_score[heap_slot[0]-1];
		res.did_scale = scaled;
		return res;
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_stall <= (cycles < hold_until) || (!calm && $urandom_range(99) < 15);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_tops.size() == 0) begin
				report_mismatch($sformatf("unexpected result var %0d", rsp_data.top_var));
			end else begin
				want = expected_tops.pop_front();
				if (rsp_data.top_var !== want.top_var)
					report_mismatch($sformatf("top_var %0d, expected %0d",
						rsp_data.top_var, want.top_var));
				if (rsp_data.top_score !== want.top_score)
					report_mismatch($sformatf("top_score %0h, expected %0h",
						rsp_data.top_score, want.top_score));
				if (rsp_data.did_scale !== want.did_scale)
					report_mismatch($sformatf("did_scale %0b, expected %0b",
						rsp_data.did_scale, want.did_scale));
			end
		end
	end

	task automatic send_request(logic [2:0] kind, int a, int b = 0, int c = 0);
		req_t rq;
		rq.req_type = kind;
		rq.var_a = a;
		rq.var_b = b;
		rq.var_c = c;
		if (!calm) begin
			while ($urandom_range(99) < 15) begin
				req_valid = 1'b0;
				@(negedge clk);
			end
		end
		req_valid = 1'b1;
		req_data = rq;
		do @(posedge clk); while (req_stall);
		expected_tops.push_back(predict_top(rq));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		wait (expected_tops.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_GROWTH: growth_q16 = value & 32'h1FFFF;
			REG_THRESH: score_limit = value & 32'h7FFFFFFF;
			REG_SHIFT: shift_amt = value & 32'h1F;
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned g, int unsigned ib, int unsigned th, int unsigned sh);
		wait_drained();
		write_reg(REG_GROWTH, g);
		write_reg(REG_BUMP, ib);
		write_reg(REG_THRESH, th);
		write_reg(REG_SHIFT, sh);
	endtask

	function automatic int pick_var();
		case ($urandom_range(19))
			0: return 0;
			1: return $urandom_range(511, 257);
			2: return NUM_VARS;
			default: return $urandom_range(var_span, 1);
		endcase
	endfunction

	task automatic test_directed();
		send_request(REQ_COUNT, NUM_VARS);
		send_request(REQ_COUNT, 0);
		send_request(REQ_COUNT, 511);
		send_request(REQ_COUNT, 257);
		send_request(3'd5, 1);
		send_request(3'd6, 2);
		send_request(3'd7, 3);
		send_request(REQ_BUMP, 5, 5, 9);
		send_request(REQ_BUMP, 0, 300, 128);
		send_request(REQ_DEACT, 5);
		send_request(REQ_DEACT, 5);
		send_request(REQ_DEACT, 256);
		send_request(REQ_REACT, 9);
		send_request(REQ_REACT, 5);
		send_request(REQ_REACT, 0);
		send_request(REQ_CLEAR, 0);
		send_request(REQ_DEACT, 1);
		send_request(REQ_BUMP, 2, 0, 0);
		send_request(REQ_BUMP, 511, 257, 3);
		send_request(REQ_DEACT, 3);
		send_request(REQ_BUMP, 3, 3, 3);
		send_request(REQ_REACT, 3);
	endtask

	task automatic test_random(int count);
		int roll;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 50) calm = 1'b1;
			if (n % 100 == 80) calm = 1'b0;
			roll = $urandom_range(99);
			if (roll < 2) send_request(REQ_CLEAR, pick_var());
			else if (roll < 30) send_request(REQ_COUNT, pick_var());
			else if (roll < 62) send_request(REQ_BUMP, pick_var(), pick_var(), pick_var());
			else if (roll < 80) send_request(REQ_DEACT, pick_var());
			else if (roll < 97) send_request(REQ_REACT, pick_var());
			else send_request(3'($urandom_range(7, 5)), pick_var());
		end
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_until = cycles + 400;
		for (int n = 0; n < 12; n++)
			send_request(REQ_BUMP, $urandom_range(16, 1), $urandom_range(16, 1), 0);
	endtask

	task automatic test_sender_pause();
		wait_drained();
		test_random(20);
	endtask

	task automatic test_saturation();
		set_config(131071, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
		for (int n = 0; n < 24; n++) send_request(REQ_BUMP, 7, 7, 8);
		send_request(REQ_COUNT, 7);
		send_request(REQ_DEACT, 7);
		send_request(REQ_REACT, 7);
		var_span = 8;
		test_random(60);
	endtask

	task automatic test_zero_bump();
		set_config(65536, 1, 1, 31);
		send_request(REQ_BUMP, 4, 4, 0);
		send_request(REQ_BUMP, 4, 0, 0);
		send_request(REQ_COUNT, 4);
		send_request(REQ_BUMP, 1, 2, 4);
		var_span = 32;
		test_random(40);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		stuck_cycles = 0;
		hold_until = 0;
		calm = 1'b0;
		var_span = 256;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		model_reset();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		var_span = 256;
		test_random(150);
		set_config(100000, 12345, 32'h200000, 4);
		var_span = 16;
		test_random(200);
		test_backpressure();
		test_sender_pause();
		set_config(65536, 65536, 32'h40000000, 14);
		var_span = 256;
		test_random(150);
		test_saturation();
		test_zero_bump();

		wait_drained();
		repeat (300) @(negedge clk);
		if (errors == 0 && expected_tops.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/vah_pkg.sv
src/vah_regs.sv
src/vah_datapath.sv
src/vah_ctrl.sv
src/vsids_activity_heap.sv
dv/vsids_activity_heap_test.sv
